// ===== sv/s3sf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package s3sf_pkg;

	localparam int unsigned PIX_W         = 8;
	localparam int unsigned ROW_W         = 16;
	localparam int unsigned WIDTH_IN_W    = 11;
	localparam int unsigned CFG_IDX_W     = 2;
	localparam int unsigned CFG_DATA_W    = 16;

	localparam int unsigned MAX_WIDTH_DEF = 1024;
	localparam int unsigned WIDTH_MIN     = 3;
	localparam int unsigned HEIGHT_MIN    = 3;
	localparam int unsigned WIDTH_RST     = 400;
	localparam int unsigned HEIGHT_RST    = 400;
	localparam logic        ENABLE_RST    = 1'b1;

	// pixels at full white are never smoothed
	localparam logic [PIX_W-1:0] WHITE    = 8'd255;

	// result queue between the filter core and the output channel
	localparam int unsigned FIFO_DEPTH    = 3;
	localparam int unsigned FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_ENABLE = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_pixel;
		logic             frame_last;
	} res_t;

endpackage

`default_nettype wire

// ===== sv/s3sf_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// pixel input channel
interface s3sf_pix_if;
	logic                        valid;
	logic                        ready;
	logic [s3sf_pkg::PIX_W-1:0]  pixel;
	logic                        flush;

	modport source (output valid, output pixel, output flush, input ready);
	modport sink   (input valid, input pixel, input flush, output ready);
endinterface

// result output channel
interface s3sf_res_if;
	logic                        valid;
	logic                        ready;
	logic [s3sf_pkg::PIX_W-1:0]  out_pixel;
	logic                        frame_last;

	modport source (output valid, output out_pixel, output frame_last, input ready);
	modport sink   (input valid, input out_pixel, input frame_last, output ready);
endinterface

// register write channel
interface s3sf_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [s3sf_pkg::CFG_IDX_W-1:0]   index;
	logic [s3sf_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/selective_3x3_smoothing_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Selective 3x3 smoothing filter. Grey pixels enter in raster order, one per
// clock while the result queue has room, and leave at the same rate: each
// interior pixel below full white becomes centre/2 plus neighbour/16 for its
// eight neighbours (terms truncated one by one); border pixels, white pixels
// and every pixel while smoothing is off pass unchanged. The result for a
// pixel is emitted on the transfer that carries the pixel width+1 places
// later, so after the last pixel of a frame the host sends width+1 flush
// items (or any items) to drain it; the last result carries frame_last and
// the next transfer starts a new frame. A result passes the stage-1 register
// and the result queue before it is presented. Both line buffers share one
// simple dual-port RAM of MAX_WIDTH x 16 bits, read at transfer time and
// written back the clock after; the throughput of one pixel per clock is set
// by that read/write pair. A three-entry result queue lets input continue
// while the sink stalls; input stalls once the queued results plus the one
// being formed reach three. Line storage needs no clearing after reset. Width
// or height writes drop any frame in progress; configure only while the block
// is idle.

module selective_3x3_smoothing_filter #(
	parameter int unsigned MAX_WIDTH = s3sf_pkg::MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	s3sf_cfg_if.sink    cfg,
	s3sf_pix_if.sink    pix,
	s3sf_res_if.source  res
);
	import s3sf_pkg::*;

	localparam int unsigned COL_W = $clog2(MAX_WIDTH);
	localparam int unsigned WID_W = $clog2(MAX_WIDTH + 1);

	// one RAM word per column: two rows above the current one
	typedef struct packed {
		logic [PIX_W-1:0] prev2;
		logic [PIX_W-1:0] prev;
	} line_ent_t;

	// ---------------- configuration ----------------
	logic [WID_W-1:0]      width_q;
	logic [ROW_W-1:0]      height_q;
	logic                  enable_q;
	logic                  cfg_fire;
	logic                  cfg_restart;
	logic [WIDTH_IN_W-1:0] cfg_w;
	logic [WID_W-1:0]      width_sat;
	logic [ROW_W-1:0]      height_sat;

	assign cfg.ready   = 1'b1;
	assign cfg_fire    = cfg.valid && cfg.ready;
	assign cfg_w       = cfg.data[WIDTH_IN_W-1:0];
	assign cfg_restart = cfg_fire &&
		((cfg.index == REG_WIDTH) || (cfg.index == REG_HEIGHT));

	// clamp width to 3..MAX_WIDTH, height to 3 and up
	always_comb begin
		if (cfg_w < WIDTH_IN_W'(WIDTH_MIN)) begin
			width_sat = WID_W'(WIDTH_MIN);
		end else if (32'(cfg_w) > MAX_WIDTH) begin
			width_sat = WID_W'(MAX_WIDTH);
		end else begin
			width_sat = WID_W'(cfg_w);
		end
		if (cfg.data[ROW_W-1:0] < ROW_W'(HEIGHT_MIN)) begin
			height_sat = ROW_W'(HEIGHT_MIN);
		end else begin
			height_sat = cfg.data[ROW_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WID_W'(WIDTH_RST);
			height_q <= ROW_W'(HEIGHT_RST);
			enable_q <= ENABLE_RST;
		end else if (cfg_fire) begin
			case (cfg_reg_t'(cfg.index))
				REG_WIDTH:  width_q  <= width_sat;
				REG_HEIGHT: height_q <= height_sat;
				REG_ENABLE: enable_q <= cfg.data[0];
				default:    ;	// unknown index: ignored
			endcase
		end
	end

	// ---------------- stage 0: transfer, counters, RAM read ----------------
	logic [COL_W-1:0] in_col_q;
	logic [ROW_W-1:0] in_row_q;
	logic [COL_W-1:0] out_col_q;
	logic [ROW_W-1:0] out_row_q;

	logic             pix_fire;
	logic             complete;
	logic             take;
	logic             emit;
	logic             in_col_last;
	logic             out_col_last;
	logic             out_row_last;
	logic             out_last;
	logic             border;
	logic [COL_W-1:0] rd_addr;

	logic [FIFO_CNT_W-1:0] fifo_count;

	assign pix_fire = pix.valid && pix.ready;
	// all rows of the frame are in: every transfer now drains one result
	assign complete = (in_row_q >= height_q);
	assign take     = pix_fire && !complete && !pix.flush;
	// outputs start with the transfer of the pixel at row 1, column 1 and then keep pace
	assign emit = (pix_fire && complete) ||
		(take && (in_row_q != '0) && ((in_row_q != ROW_W'(1)) || (in_col_q != '0)));

	assign in_col_last  = ((WID_W'(in_col_q) + WID_W'(1)) == width_q);
	assign out_col_last = ((WID_W'(out_col_q) + WID_W'(1)) == width_q);
	assign out_row_last = (((ROW_W + 1)'(out_row_q) + (ROW_W + 1)'(1)) >=
		(ROW_W + 1)'(height_q));
	assign out_last     = out_row_last && out_col_last;
	assign border       = (out_row_q == '0) || out_row_last ||
		(out_col_q == '0) || out_col_last;

	// draining reads the stored rows at the output column
	assign rd_addr = complete ? out_col_q : in_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_restart) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else begin
			if (take) begin
				if (in_col_last) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + ROW_W'(1);
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
			end
			if (emit) begin
				if (out_last) begin
					// end of frame: next transfer opens a new one
					in_col_q  <= '0;
					in_row_q  <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
				end else if (out_col_last) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + ROW_W'(1);
				end else begin
					out_col_q <= out_col_q + COL_W'(1);
				end
			end
		end
	end

	// ---------------- line RAM ----------------
	line_ent_t        line_mem [MAX_WIDTH];
	line_ent_t        mem_rd_q;
	line_ent_t        byp_data_q;
	logic             byp_q;
	line_ent_t        rd_ent;
	line_ent_t        wr_ent;
	logic             wr_en_s1;
	logic [COL_W-1:0] col_s1;

	// write-back of the item ahead lands on the same edge as this read
	always_ff @(posedge clk) begin
		if (pix_fire) begin
			mem_rd_q   <= line_mem[rd_addr];
			byp_q      <= wr_en_s1 && (col_s1 == rd_addr);
			byp_data_q <= wr_ent;
		end
		if (wr_en_s1) begin
			line_mem[col_s1] <= wr_ent;
		end
	end

	assign rd_ent = byp_q ? byp_data_q : mem_rd_q;

	// ---------------- stage 1: window, result, RAM write-back ----------------
	logic             take_s1;
	logic             emit_s1;
	logic             pass_s1;
	logic             last_s1;
	logic             row_last_s1;
	logic [PIX_W-1:0] px_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			take_s1 <= 1'b0;
			emit_s1 <= 1'b0;
		end else begin
			take_s1 <= take;
			emit_s1 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_fire) begin
			col_s1      <= rd_addr;
			px_s1       <= pix.pixel;
			pass_s1     <= border || !enable_q;
			last_s1     <= out_last;
			row_last_s1 <= out_row_last;
		end
	end

	// row shift: prev moves down to prev2, new pixel becomes prev
	assign wr_en_s1     = take_s1;
	assign wr_ent.prev2 = rd_ent.prev;
	assign wr_ent.prev  = px_s1;

	// two stored columns; the third is the column arriving now
	logic [PIX_W-1:0] win_q   [3][2];
	logic [PIX_W-1:0] new_col [3];
	logic [PIX_W-1:0] centre;
	logic [PIX_W-1:0] smooth_sum;
	logic [PIX_W-1:0] res_pixel;

	assign new_col[0] = rd_ent.prev2;
	assign new_col[1] = rd_ent.prev;
	assign new_col[2] = px_s1;
	assign centre     = win_q[1][1];

	always_ff @(posedge clk) begin
		if (take_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= new_col[r];
			end
		end
	end

	// max is 127 + 8*15 = 247, no overflow
	always_comb begin
		smooth_sum = PIX_W'(centre[PIX_W-1:1]);
		for (int r = 0; r < 3; r++) begin
			smooth_sum = smooth_sum + PIX_W'(win_q[r][0][PIX_W-1:4]) +
				PIX_W'(new_col[r][PIX_W-1:4]);
			if (r != 1) begin
				smooth_sum = smooth_sum + PIX_W'(win_q[r][1][PIX_W-1:4]);
			end
		end
	end

	always_comb begin
		if (!take_s1) begin
			// drain: bottom row from prev, the row above from prev2
			res_pixel = row_last_s1 ? rd_ent.prev : rd_ent.prev2;
		end else if (pass_s1 || (centre == WHITE)) begin
			res_pixel = centre;
		end else begin
			res_pixel = smooth_sum;
		end
	end

	// ---------------- result queue ----------------
	res_t push_data;

	assign push_data.out_pixel  = res_pixel;
	assign push_data.frame_last = last_s1;

	// room for the item in stage 1 and one more behind it
	assign pix.ready = (((FIFO_CNT_W + 1)'(fifo_count) + (FIFO_CNT_W + 1)'(emit_s1)) <
		(FIFO_CNT_W + 1)'(FIFO_DEPTH));

	s3sf_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit_s1),
		.push_data (push_data),
		.count     (fifo_count),
		.res       (res)
	);

endmodule

`default_nettype wire

// ===== sv/s3sf_out_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module s3sf_out_fifo (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  s3sf_pkg::res_t                   push_data,
	output logic [s3sf_pkg::FIFO_CNT_W-1:0]  count,
	s3sf_res_if.source                       res
);
	import s3sf_pkg::*;

	localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);

	res_t                  slot_q [FIFO_DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  pop;

	assign pop           = res.valid && res.ready;
	assign res.valid     = (count_q != '0);
	assign res.out_pixel = slot_q[rd_ptr_q].out_pixel;
	assign res.frame_last = slot_q[rd_ptr_q].frame_last;
	assign count         = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== sv/s3sf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module s3sf_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [s3sf_pkg::PIX_W-1:0]  out_pixel,
	input wire logic                        out_frame_last
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_pixel) && $stable(out_frame_last))
		else $error("result changed while stalled");

	// input is only held off when results are backed up
	a_ready_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

	// a newly valid result goes back to a causing transfer, via stage 1 and the queue
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a causing transfer");

	// moving both sides keeps the input open
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && out_valid && out_ready |=> in_ready)
		else $error("input closed while flowing");

endmodule

bind selective_3x3_smoothing_filter s3sf_checker u_s3sf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (pix.valid),
	.in_ready       (pix.ready),
	.out_valid      (res.valid),
	.out_ready      (res.ready),
	.out_pixel      (res.out_pixel),
	.out_frame_last (res.frame_last)
);

`default_nettype wire

// ===== test/selective_3x3_smoothing_filter_tb.sv =====
`timescale 1ns / 1ps

module selective_3x3_smoothing_filter_tb;
	import s3sf_pkg::*;

	localparam int unsigned LINE_DEPTH     = MAX_WIDTH_DEF;
	// results leave through the stage-1 register and the queue; leave margin before register writes
	localparam int unsigned SETTLE_CYCLES  = 8;
	localparam int unsigned TAIL_CYCLES    = 16;
	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned RANDOM_ITEMS   = 300;
	localparam int unsigned MAX_REPORTS    = 10;
	// index past the last register; the block must ignore writes to it
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// how frame content is drawn
	typedef enum int {
		PIX_RANDOM,
		PIX_WHITE_HEAVY,
		PIX_EXTREMES
	} pix_style_t;

	logic clk = 1'b0;
	logic arst_n;

	s3sf_cfg_if cfg_ch ();
	s3sf_pix_if pix_ch ();
	s3sf_res_if res_ch ();

	selective_3x3_smoothing_filter u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.pix    (pix_ch),
		.res    (res_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Filter model: register copies, line buffers, window and counters.
	// Counters are kept as plain ints so that the wrap checks never
	// overflow at the widest frame or the tallest height.
	// ------------------------------------------------------------------
	logic [WIDTH_IN_W-1:0] mdl_width;
	logic [ROW_W-1:0]      mdl_height;
	logic                  mdl_enable;
	logic [PIX_W-1:0]      line_above  [LINE_DEPTH];
	logic [PIX_W-1:0]      line_above2 [LINE_DEPTH];
	logic [PIX_W-1:0]      win [3][3];
	int unsigned           col_in, row_in, col_out, row_out;

	// results still owed by the block, oldest first
	res_t expected_pixels [$];

	int unsigned failures;
	int unsigned results_checked;
	int unsigned items_sent;
	int unsigned frames_done;
	int unsigned stall_left;
	int unsigned quiet_cycles;
	bit          no_idle;

	// back to the first pixel of a frame; line buffers keep their contents
	function automatic void clear_frame_position();
		int r, c;
		for (r = 0; r < 3; r++)
			for (c = 0; c < 3; c++)
				win[r][c] = '0;
		col_in  = 0;
		row_in  = 0;
		col_out = 0;
		row_out = 0;
	endfunction

	// Advance the model by one transfer. Returns 1 when the transfer
	// releases a result, which is then placed in r.
	function automatic bit predict_filter(input logic [PIX_W-1:0] px, input logic fl,
		output res_t r);
		int unsigned      i, j, received, needed, s;
		logic [PIX_W-1:0] centre;
		bit               border, is_last;
		r = '0;
		if (row_in < mdl_height) begin
			// flush while the frame still takes pixels: nothing happens
			if (fl)
				return 0;
			for (i = 0; i < 3; i++) begin
				win[i][0] = win[i][1];
				win[i][1] = win[i][2];
			end
			win[0][2] = line_above2[col_in];
			win[1][2] = line_above[col_in];
			win[2][2] = px;
			line_above2[col_in] = line_above[col_in];
			line_above[col_in]  = px;
			col_in++;
			if (col_in >= mdl_width) begin
				col_in = 0;
				row_in++;
			end
			// output trails input by one row plus one pixel
			received = row_in * mdl_width + col_in;
			needed   = row_out * mdl_width + col_out + mdl_width + 2;
			if (received < needed)
				return 0;
			centre = win[1][1];
			border = row_out == 0 || row_out + 1 >= mdl_height ||
				col_out == 0 || col_out + 1 >= mdl_width;
			if (border || !mdl_enable || centre == WHITE) begin
				r.out_pixel = centre;
			end else begin
				// each term truncated on its own; sum tops out at 247
				s = 32'(centre) >> 1;
				for (i = 0; i < 3; i++)
					for (j = 0; j < 3; j++)
						if (i != 1 || j != 1)
							s += 32'(win[i][j]) >> 4;
				r.out_pixel = s[PIX_W-1:0];
			end
		end else begin
			// draining: remaining results are the bottom border, straight from the lines
			r.out_pixel = (row_out + 1 >= mdl_height) ? line_above[col_out] :
				line_above2[col_out];
		end
		is_last = row_out + 1 >= mdl_height && col_out + 1 >= mdl_width;
		r.frame_last = is_last;
		if (is_last) begin
			clear_frame_position();
		end else begin
			col_out++;
			if (col_out >= mdl_width) begin
				col_out = 0;
				row_out++;
			end
		end
		return 1;
	endfunction

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_idle)
			return 0;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 2);
		if (r < 97)
			return $urandom_range(3, 8);
		return $urandom_range(12, 40);
	endfunction

	function automatic logic [PIX_W-1:0] pick_pixel(input pix_style_t style);
		int unsigned r;
		r = $urandom_range(3);
		if (style == PIX_WHITE_HEAVY)
			return (r < 2) ? WHITE : PIX_W'($urandom_range(255));
		if (style == PIX_EXTREMES) begin
			if (r == 0)
				return 8'd0;
			if (r == 1)
				return WHITE;
			if (r == 2)
				return 8'd254;
			return PIX_W'($urandom_range(255));
		end
		return PIX_W'($urandom_range(255));
	endfunction

	// ------------------------------------------------------------------
	// Transfer helpers
	// ------------------------------------------------------------------

	// One pixel-channel transfer. valid stays high on return so that a
	// following call with no gap streams without a bubble; wait_drained
	// drops it as soon as it is called.
	task automatic send_item(input logic [PIX_W-1:0] px, input logic fl);
		int unsigned gap;
		res_t        r;
		gap = pick_gap();
		if (gap != 0) begin
			pix_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.pixel <= px;
		pix_ch.flush <= fl;
		do @(posedge clk); while (pix_ch.ready !== 1'b1);
		// ignored flushes do not count as stimulus
		if (!(fl && row_in < mdl_height))
			items_sent++;
		if (predict_filter(px, fl, r)) begin
			expected_pixels.push_back(r);
			if (r.frame_last)
				frames_done++;
		end
	endtask

	// idle the input, let every owed result arrive, then wait out the pipeline
	task automatic wait_drained();
		pix_ch.valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write, only with the block idle; model follows the same saturation
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		logic [WIDTH_IN_W-1:0] w;
		logic [ROW_W-1:0]      h;
		wait_drained();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		case (idx)
			REG_WIDTH: begin
				w = data[WIDTH_IN_W-1:0];
				if (w < WIDTH_MIN)
					w = WIDTH_IN_W'(WIDTH_MIN);
				else if (w > MAX_WIDTH_DEF)
					w = WIDTH_IN_W'(MAX_WIDTH_DEF);
				mdl_width = w;
				clear_frame_position();
			end
			REG_HEIGHT: begin
				h = data;
				if (h < HEIGHT_MIN)
					h = ROW_W'(HEIGHT_MIN);
				mdl_height = h;
				clear_frame_position();
			end
			REG_ENABLE: mdl_enable = data[0];
			default: ;
		endcase
	endtask

	// count pixels, with an ignored flush slipped in now and then
	task automatic send_pixels(input int unsigned count, input pix_style_t style,
		input int unsigned noise_pct);
		int unsigned n;
		for (n = 0; n < count; n++) begin
			if (noise_pct != 0 && $urandom_range(99) < noise_pct)
				send_item(PIX_W'($urandom_range(255)), 1'b1);
			send_item(pick_pixel(style), 1'b0);
		end
	endtask

	// width+1 drain items, a mix of flushes and stray pixels
	task automatic send_drain();
		int unsigned n, total;
		total = mdl_width + 1;
		for (n = 0; n < total; n++)
			send_item(PIX_W'($urandom_range(255)), 1'($urandom_range(1)));
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// reset geometry is 400 wide: a short run into the first row must give
	// no result yet; the next width write drops the frame
	task automatic test_reset_values();
		send_item(8'h00, 1'b1);
		send_pixels(30, PIX_RANDOM, 0);
		wait_drained();
	endtask

	// smallest frame, built by hand: full-white ring around 254 gives the
	// largest smoothed value; a white centre passes untouched
	task automatic test_directed_cases();
		int unsigned n;
		write_register(REG_WIDTH, 16'h0803);   // upper bits dropped, leaving 3
		write_register(REG_HEIGHT, 16'd0);     // raised to 3
		send_item(8'hA5, 1'b1);                // flush with no frame input: ignored
		for (n = 0; n < 9; n++)
			send_item((n == 4) ? 8'd254 : WHITE, 1'b0);
		send_item(8'h00, 1'b1);
		send_item(8'hFF, 1'b1);
		send_item(8'h00, 1'b0);                // pixels after the frame act as drains
		send_item(8'hFF, 1'b0);
		for (n = 0; n < 9; n++)
			send_item((n == 4) ? WHITE : 8'd0, 1'b0);
		send_item(8'h5A, 1'b0);
		send_item(8'hA5, 1'b1);
		send_item(8'h3C, 1'b0);
		send_item(8'hC3, 1'b1);
		wait_drained();
	endtask

	// enable toggled inside a frame (no restart), then a height write that
	// throws away a half-sent frame
	task automatic test_midframe_writes();
		write_register(REG_WIDTH, 16'd5);
		write_register(REG_HEIGHT, 16'd6);
		write_register(REG_ENABLE, 16'd1);
		send_pixels(14, PIX_WHITE_HEAVY, 0);
		write_register(REG_ENABLE, 16'd0);
		send_pixels(8, PIX_WHITE_HEAVY, 0);
		write_register(REG_ENABLE, 16'd1);
		send_pixels(8, PIX_WHITE_HEAVY, 0);
		send_drain();
		write_register(REG_HEIGHT, 16'd4);
		send_pixels(7, PIX_EXTREMES, 0);
		write_register(REG_HEIGHT, 16'd5);
		send_pixels(25, PIX_EXTREMES, 0);
		send_drain();
		wait_drained();
	endtask

	// tallest height on the narrowest width: many rows, frame left unfinished
	task automatic test_tallest_frame();
		write_register(REG_WIDTH, 16'd1);      // raised to 3
		write_register(REG_HEIGHT, 16'hFFFF);
		send_pixels(3 * 50, PIX_EXTREMES, 10);
		wait_drained();
	endtask

	// widest line, a write to the unused index in between; a short run
	// into the first row must give no result on a line this wide
	task automatic test_widest_frame();
		write_register(REG_WIDTH, 16'h07FF);   // capped at 1024
		write_register(REG_UNUSED, 16'hFFFF);
		write_register(REG_HEIGHT, 16'd3);
		send_pixels(20, PIX_RANDOM, 0);
		wait_drained();
	endtask

	// random geometry and content per frame; some frames are cut short and
	// dropped by the next width write, some run with no idling at all
	task automatic test_random_frames();
		int unsigned           start, w;
		logic [CFG_DATA_W-1:0] data;
		pix_style_t            style;
		start = items_sent;
		while (items_sent < start + RANDOM_ITEMS) begin
			w = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 8);
			data = CFG_DATA_W'(($urandom_range(31) << WIDTH_IN_W) | w);
			write_register(REG_WIDTH, data);
			write_register(REG_HEIGHT, CFG_DATA_W'($urandom_range(0, 8)));
			write_register(REG_ENABLE, CFG_DATA_W'($urandom_range(3) != 0));
			style = pix_style_t'($urandom_range(2));
			no_idle = ($urandom_range(3) == 0);
			if ($urandom_range(9) == 0) begin
				send_pixels($urandom_range(1, mdl_width * mdl_height - 1), style, 4);
			end else begin
				send_pixels(mdl_width * mdl_height, style, 4);
				send_drain();
			end
			no_idle = 1'b0;
		end
		wait_drained();
	endtask

	// ------------------------------------------------------------------
	// Result sink: random stalls, none while no_idle is set
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (stall_left != 0) begin
			res_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			res_ch.ready <= 1'b1;
			if (!no_idle && $urandom_range(2) == 0)
				stall_left = pick_gap();
		end
	end

	// every result transfer is matched against the oldest owed pixel
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (expected_pixels.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("unexpected result: out_pixel %0d frame_last %0b",
						res_ch.out_pixel, res_ch.frame_last);
			end else begin
				want = expected_pixels.pop_front();
				results_checked++;
				if (res_ch.out_pixel !== want.out_pixel ||
					res_ch.frame_last !== want.frame_last) begin
					failures++;
					if (failures <= MAX_REPORTS)
						$display("result %0d: expected out_pixel %0d frame_last %0b, got out_pixel %0d frame_last %0b",
							results_checked, want.out_pixel, want.frame_last,
							res_ch.out_pixel, res_ch.frame_last);
				end
			end
		end
	end

	// watchdog: cycles in a row with no transfer on any channel
	always @(posedge clk) begin
		if ((pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1) ||
			(res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
			(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("watchdog: no transfer for %0d cycles, %0d results still owed",
			quiet_cycles, expected_pixels.size());
		$display("FAILURE");
		$finish;
	end

	initial begin
		int i;
		pix_ch.valid = 1'b0;
		pix_ch.pixel = '0;
		pix_ch.flush = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_WIDTH;
		cfg_ch.data  = '0;
		res_ch.ready = 1'b0;
		arst_n       = 1'b0;
		no_idle      = 1'b0;
		stall_left   = 0;
		quiet_cycles = 0;
		failures     = 0;
		results_checked = 0;
		items_sent   = 0;
		frames_done  = 0;

		mdl_width  = WIDTH_IN_W'(WIDTH_RST);
		mdl_height = ROW_W'(HEIGHT_RST);
		mdl_enable = ENABLE_RST;
		for (i = 0; i < LINE_DEPTH; i++) begin
			line_above[i]  = '0;
			line_above2[i] = '0;
		end
		clear_frame_position();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_directed_cases();
		test_midframe_writes();
		test_tallest_frame();
		test_widest_frame();
		test_random_frames();

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_pixels.size() != 0) begin
			$display("%0d results never arrived", expected_pixels.size());
			failures += expected_pixels.size();
		end

		$display("Ran %0d pixel and drain transfers, %0d results checked, %0d frames completed",
			items_sent, results_checked, frames_done);
		$display("Widths 3 to 1024, heights 3 to 65535, smoothing on and off, gaps on both sides");
		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
